[rtl/core/grc_pkg.sv]
package grc_pkg;

    localparam int GRID_COLS       = 64;
    localparam int GRID_ROWS       = 64;
    localparam int PLANES          = 3;
    localparam int CELLS_PER_PLANE = GRID_COLS * GRID_ROWS;
    localparam int STORE_DEPTH     = PLANES * CELLS_PER_PLANE;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);

    localparam int CMD_W   = 2;
    localparam int PLANE_W = 2;
    localparam int COL_W   = 6;
    localparam int ROW_W   = 6;
    localparam int BYTE_W  = 8;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE     = 2'd0,
        CMD_READ      = 2'd1,
        CMD_SKEW_UP   = 2'd2,
        CMD_SKEW_DOWN = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_RESP,
        ST_LOAD,
        ST_LOAD_DRAIN,
        ST_STORE,
        ST_STORE_DRAIN
    } t_state;

    // Flat store address of one cell: planes, then rows, then columns.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [PLANE_W-1:0] plane,
        input logic [COL_W-1:0]   col,
        input logic [ROW_W-1:0]   row
    );
        int unsigned flat;
        flat = int'(plane) * CELLS_PER_PLANE + int'(row) * GRID_COLS + int'(col);
        return flat[ADDR_W-1:0];
    endfunction

endpackage

[rtl/core/grc_ram.sv]
module grc_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/grid_region_column_skew_core.sv]
// A cell write and a reversed, off-grid or single-column skew set the result register at
// the accepting edge; a cell read sets it from ST_READ_RESP, after the registered grid read.
// A skew of C extra columns over H rows works column by column: each column is loaded into
// the column buffer (ST_LOAD, ST_LOAD_DRAIN) and written back rotated (ST_STORE, ST_STORE_DRAIN).
// Throughput is one item at a time; the next item is taken once the previous one is done.
// Reset (synchronous, active low) enters ST_CLEAR, which zeroes the grid; no item is taken meanwhile.
module grid_region_column_skew_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // From bit 0 up: command[1:0], plane[3:2], col_start[9:4], row_start[15:10],
    // col_end[21:16], row_end[27:22], cell_value[35:28], zero pad [39:36].
    input  logic [grc_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // From bit 0 up: read_value[7:0], status[8], zero pad [15:9].
    output logic [grc_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    import grc_pkg::*;

    localparam int BUF_DEPTH  = GRID_ROWS;
    localparam int BUF_ADDR_W = $clog2(BUF_DEPTH);

    // Fields of the incoming item.
    t_cmd               in_cmd;
    logic [PLANE_W-1:0] in_plane;
    logic [COL_W-1:0]   in_c0;
    logic [ROW_W-1:0]   in_r0;
    logic [COL_W-1:0]   in_c1;
    logic [ROW_W-1:0]   in_r1;
    logic [BYTE_W-1:0]  in_value;
    logic               in_cell_ok;
    logic               in_accept;

    assign in_cmd   = t_cmd'(i_s_tdata[1:0]);
    assign in_plane = i_s_tdata[3:2];
    assign in_c0    = i_s_tdata[9:4];
    assign in_r0    = i_s_tdata[15:10];
    assign in_c1    = i_s_tdata[21:16];
    assign in_r1    = i_s_tdata[27:22];
    assign in_value = i_s_tdata[35:28];

    // The start cell must lie inside the grid for any command to touch the store.
    assign in_cell_ok = (int'(in_plane) < PLANES) && (int'(in_c0) < GRID_COLS)
                     && (int'(in_r0) < GRID_ROWS);

    // Sequencer state and the skew context.
    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_clr, n_clr;
    logic [PLANE_W-1:0] r_plane, n_plane;
    logic [COL_W-1:0]   r_col, n_col;
    logic [COL_W-1:0]   r_c1, n_c1;
    logic [ROW_W-1:0]   r_r0, n_r0;
    logic [ROW_W-1:0]   r_hm1, n_hm1;      // region height minus one
    logic               r_up, n_up;
    logic [ROW_W-1:0]   r_cnt, n_cnt;      // row offset being issued
    logic [ROW_W-1:0]   r_k, n_k;          // rotation of the current column, mod height
    logic [ROW_W-1:0]   r_src, n_src;      // buffer row that feeds the current offset
    logic               r_rdok, n_rdok;

    // Registered write slots that line up with the registered memory reads.
    logic               r_bwv, n_bwv;
    logic [ROW_W-1:0]   r_bwrow, n_bwrow;
    logic               r_gwv, n_gwv;
    logic [ROW_W-1:0]   r_gwrow, n_gwrow;

    // Result register.
    logic               r_ovalid, n_ovalid;
    logic [BYTE_W-1:0]  r_oval, n_oval;
    logic               r_ostat, n_ostat;

    // Memory ports.
    logic                  grid_we;
    logic [ADDR_W-1:0]     grid_waddr;
    logic [BYTE_W-1:0]     grid_wdata;
    logic [ADDR_W-1:0]     grid_raddr;
    logic [BYTE_W-1:0]     grid_rdata;
    logic                  buf_we;
    logic [BUF_ADDR_W-1:0] buf_waddr;
    logic [BUF_ADDR_W-1:0] buf_raddr;
    logic [BYTE_W-1:0]     buf_rdata;

    logic [ROW_W-1:0]   src_init;
    logic [ROW_W-1:0]   k_next;

    grc_ram #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (BYTE_W)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_waddr (grid_waddr),
        .i_wdata (grid_wdata),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rdata)
    );

    grc_ram #(
        .DEPTH  (BUF_DEPTH),
        .ADDR_W (BUF_ADDR_W),
        .DATA_W (BYTE_W)
    ) u_colbuf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (grid_rdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    // Accept only when idle and the result register is free by the same edge.
    assign o_s_tready = (r_state == ST_IDLE) && (!r_ovalid || i_m_tready);
    assign in_accept  = i_s_tvalid && o_s_tready;

    // Skew up reads row (r - k) mod h, skew down reads row (r + k) mod h; both start
    // at offset zero and then step by one with a wrap at the region height.
    assign src_init = r_up ? ((r_k == '0) ? '0 : ROW_W'(r_hm1 - r_k + 1'b1)) : r_k;
    assign k_next   = (r_k == r_hm1) ? '0 : ROW_W'(r_k + 1'b1);

    // Column buffer: filled from the grid read in the cycle after the read is issued.
    assign buf_we    = r_bwv;
    assign buf_waddr = BUF_ADDR_W'(r_bwrow);
    assign buf_raddr = BUF_ADDR_W'(r_src);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_plane  = r_plane;
        n_col    = r_col;
        n_c1     = r_c1;
        n_r0     = r_r0;
        n_hm1    = r_hm1;
        n_up     = r_up;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_src    = r_src;
        n_rdok   = r_rdok;
        n_bwv    = 1'b0;
        n_bwrow  = r_cnt;
        n_gwv    = 1'b0;
        n_gwrow  = r_cnt;
        n_ovalid = r_ovalid;
        n_oval   = r_oval;
        n_ostat  = r_ostat;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        // A pending write-back of a rotated cell has the grid write port first.
        grid_we    = r_gwv;
        grid_waddr = cell_addr(r_plane, r_col, ROW_W'(r_r0 + r_gwrow));
        grid_wdata = buf_rdata;
        grid_raddr = cell_addr(r_plane, r_col, ROW_W'(r_r0 + r_cnt));

        unique case (r_state)
            ST_CLEAR: begin
                grid_we    = 1'b1;
                grid_waddr = r_clr;
                grid_wdata = '0;
                n_clr      = ADDR_W'(r_clr + 1'b1);
                if (int'(r_clr) == STORE_DEPTH - 1) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                grid_raddr = in_cell_ok ? cell_addr(in_plane, in_c0, in_r0) : '0;
                if (in_accept) begin
                    n_oval  = '0;
                    n_ostat = 1'b0;
                    if (in_cmd == CMD_WRITE) begin
                        grid_we    = in_cell_ok;
                        grid_waddr = cell_addr(in_plane, in_c0, in_r0);
                        grid_wdata = in_value;
                        n_ovalid   = 1'b1;
                    end else if (in_cmd == CMD_READ) begin
                        n_rdok  = in_cell_ok;
                        n_state = ST_READ_RESP;
                    end else if ((in_c1 < in_c0) || (in_r1 < in_r0)) begin
                        n_ostat  = 1'b1;
                        n_ovalid = 1'b1;
                    end else if (!in_cell_ok || (in_c1 == in_c0)) begin
                        n_ovalid = 1'b1;
                    end else begin
                        // The first column stays; the second is rotated by one place.
                        n_plane = in_plane;
                        n_col   = COL_W'(in_c0 + 1'b1);
                        n_c1    = in_c1;
                        n_r0    = in_r0;
                        n_hm1   = ROW_W'(in_r1 - in_r0);
                        n_up    = (in_cmd == CMD_SKEW_UP);
                        n_k     = (in_r1 == in_r0) ? '0 : ROW_W'(1);
                        n_cnt   = '0;
                        n_state = ST_LOAD;
                    end
                end
            end

            ST_READ_RESP: begin
                n_oval   = r_rdok ? grid_rdata : '0;
                n_ovalid = 1'b1;
                n_state  = ST_IDLE;
            end

            ST_LOAD: begin
                n_bwv   = 1'b1;
                n_bwrow = r_cnt;
                if (r_cnt == r_hm1) begin
                    n_cnt   = '0;
                    n_state = ST_LOAD_DRAIN;
                end else begin
                    n_cnt = ROW_W'(r_cnt + 1'b1);
                end
            end

            ST_LOAD_DRAIN: begin
                n_src   = src_init;
                n_state = ST_STORE;
            end

            ST_STORE: begin
                n_gwv   = 1'b1;
                n_gwrow = r_cnt;
                n_src   = (r_src == r_hm1) ? '0 : ROW_W'(r_src + 1'b1);
                if (r_cnt == r_hm1) begin
                    n_cnt   = '0;
                    n_state = ST_STORE_DRAIN;
                end else begin
                    n_cnt = ROW_W'(r_cnt + 1'b1);
                end
            end

            ST_STORE_DRAIN: begin
                if (r_col == r_c1) begin
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_col   = COL_W'(r_col + 1'b1);
                    n_k     = k_next;
                    n_state = ST_LOAD;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_bwv    <= 1'b0;
            r_gwv    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_bwv    <= n_bwv;
            r_gwv    <= n_gwv;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plane <= n_plane;
        r_col   <= n_col;
        r_c1    <= n_c1;
        r_r0    <= n_r0;
        r_hm1   <= n_hm1;
        r_up    <= n_up;
        r_cnt   <= n_cnt;
        r_k     <= n_k;
        r_src   <= n_src;
        r_rdok  <= n_rdok;
        r_bwrow <= n_bwrow;
        r_gwrow <= n_gwrow;
        r_oval  <= n_oval;
        r_ostat <= n_ostat;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(OUT_DATA_W - BYTE_W - 1){1'b0}}, r_ostat, r_oval};

endmodule
